FILE: design/diff_drive_slew_limiter_core_assert.svh
// Assertion helpers for the slew limiter core. Both sample on clk and stay quiet in reset.
`ifndef DIFF_DRIVE_SLEW_LIMITER_CORE_ASSERT_SVH
`define DIFF_DRIVE_SLEW_LIMITER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDSL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ddsl_pkg.sv
`timescale 1ns / 1ps

package ddsl_pkg;

    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned RADIUS_W   = 12;
    localparam int unsigned ACCEL_W    = 16;
    localparam int unsigned PERIOD_W   = 10;
    localparam int unsigned SCALE_W    = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // Wheel target numerator 1000*v -/+ R*w stays below 2^28 in magnitude.
    localparam int unsigned NUM_W  = 29;
    localparam int unsigned MAG_W  = 28;
    localparam int unsigned QUOT_W = 18;
    localparam int unsigned STEP_W = 17;

    // floor(x / 1000) as (x * ceil(2^38 / 1000)) >> 38, exact for x below 2^28.
    localparam int unsigned DIV_MUL_W     = 29;
    localparam int unsigned DIV1000_SHIFT = 38;
    localparam logic [DIV_MUL_W-1:0] DIV1000_MUL = 29'd274877907;

    localparam logic signed [NUM_W-1:0] KILO = 29'sd1000;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 12'd100;
    localparam logic [ACCEL_W-1:0]  ACCEL_RST  = 16'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd10;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_ACCEL  = 2'd1,
        CFG_PERIOD = 2'd2,
        CFG_SCALE  = 2'd3
    } cfg_reg_e;

    typedef enum logic {
        FUNC_CMD  = 1'b0,
        FUNC_TICK = 1'b1
    } func_e;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [ACCEL_W-1:0]  accel;
        logic [PERIOD_W-1:0] period;
        logic [SCALE_W-1:0]  scale;
    } cfg_t;

    // Wheel targets as sign and magnitude of the truncated quotient.
    typedef struct packed {
        func_e             func;
        logic              neg_l;
        logic [QUOT_W-1:0] quot_l;
        logic              neg_r;
        logic [QUOT_W-1:0] quot_r;
    } wheel_tgt_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] sp_l;
        logic signed [FIELD_W-1:0] sp_r;
    } sp_pair_t;

    function automatic logic [QUOT_W-1:0] div1000(input logic [MAG_W-1:0] mag);
        logic [MAG_W+DIV_MUL_W-1:0] prod;
        prod = {{DIV_MUL_W{1'b0}}, mag} * {{MAG_W{1'b0}}, DIV1000_MUL};
        return prod[DIV1000_SHIFT +: QUOT_W];
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat16(input logic signed [QUOT_W:0] x);
        logic signed [FIELD_W-1:0] res;
        if (x > 19'sd32767)
        begin
            res = 16'sh7FFF;
        end
        else if (x < -19'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = x[FIELD_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/ddsl_cmd_if.sv
`timescale 1ns / 1ps

interface ddsl_cmd_if import ddsl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [FIELD_W-1:0] lin_speed;
    logic signed [FIELD_W-1:0] turn_rate;

    modport source (output valid, output func, output lin_speed, output turn_rate, input ready);
    modport sink (input valid, input func, input lin_speed, input turn_rate, output ready);
endinterface

FILE: design/ddsl_rpm_if.sv
`timescale 1ns / 1ps

interface ddsl_rpm_if import ddsl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] left_rpm;
    logic signed [FIELD_W-1:0] right_rpm;

    modport source (output valid, output left_rpm, output right_rpm, input ready);
    modport sink (input valid, input left_rpm, input right_rpm, output ready);
endinterface

FILE: design/diff_drive_slew_limiter_core.sv
`timescale 1ns / 1ps
// Channel   Role    Carries
// cmd       sink    func, lin_speed, turn_rate (motion command or time tick)
// rpm       source  left_rpm, right_rpm (one per tick, none per command)
//
// Takes one item per cycle unless the rpm channel holds it back. A tick's result passes
// stages a, b, c, the setpoint register, p and out; a command updates the wheel targets
// after stages a, b and c, in item order. The depth is set by the two multiplier stages
// of the target path and the rpm multiply. Reset loads the default configuration and
// clears targets, setpoints and all valids. Every stage holds while the next one is full,
// so input keeps flowing over bubbles while a result waits on the rpm channel.

module diff_drive_slew_limiter_core import ddsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ddsl_cmd_if.sink              cmd,
    ddsl_rpm_if.source            rpm,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [RADIUS_W-1:0] radius_reg;
    logic [ACCEL_W-1:0]  accel_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [SCALE_W-1:0]  scale_reg;
    cfg_t                cfg;

    logic       tgt_valid;
    logic       tgt_ready;
    wheel_tgt_t tgt_item;
    logic       sp_valid;
    logic       sp_ready;
    sp_pair_t   sp_item;

    logic       out_free;
    logic       cmd_done;
    logic       tick_done;

    assign cfg.radius = radius_reg;
    assign cfg.accel  = accel_reg;
    assign cfg.period = period_reg;
    assign cfg.scale  = scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            accel_reg  <= ACCEL_RST;
            period_reg <= PERIOD_RST;
            scale_reg  <= SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_RADIUS: radius_reg <= cfg_wdata[RADIUS_W-1:0];
                CFG_ACCEL:  accel_reg  <= cfg_wdata[ACCEL_W-1:0];
                CFG_PERIOD: period_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_SCALE:  scale_reg  <= cfg_wdata[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ddsl_target u_target
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .tgt_valid (tgt_valid),
        .tgt_ready (tgt_ready),
        .tgt_item  (tgt_item)
    );

    ddsl_slew u_slew
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tgt_valid (tgt_valid),
        .tgt_ready (tgt_ready),
        .tgt_item  (tgt_item),
        .sp_valid  (sp_valid),
        .sp_ready  (sp_ready),
        .sp_item   (sp_item)
    );

    ddsl_rpm u_rpm
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .sp_valid (sp_valid),
        .sp_ready (sp_ready),
        .sp_item  (sp_item),
        .rpm      (rpm)
    );

    assign out_free  = rpm.ready || !rpm.valid;
    assign cmd_done  = tgt_valid && tgt_ready && (tgt_item.func == FUNC_CMD) &&
                       !(sp_valid && !sp_ready);
    assign tick_done = tgt_valid && tgt_ready && (tgt_item.func == FUNC_TICK);

`include "diff_drive_slew_limiter_core_assert.svh"

    // With room at the output every stage can move, so input must be open.
    `DDSL_ASSERT_SAME(a_ready_chain, out_free, cmd.ready, "input blocked with free output")

    `DDSL_ASSERT_NEXT(a_cmd_no_result, cmd_done, !sp_valid, "command produced a setpoint item")

    `DDSL_ASSERT_NEXT(a_tick_result, tick_done, sp_valid, "tick produced no setpoint item")

endmodule

FILE: design/ddsl_target.sv
`timescale 1ns / 1ps

module ddsl_target import ddsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    ddsl_cmd_if.sink   cmd,
    output logic       tgt_valid,
    input  logic       tgt_ready,
    output wheel_tgt_t tgt_item
);

    logic                      a_valid_reg;
    logic                      a_func_reg;
    logic signed [FIELD_W-1:0] a_v_reg;
    logic signed [FIELD_W-1:0] a_w_reg;

    logic                    b_valid_reg;
    func_e                   b_func_reg;
    logic signed [NUM_W-1:0] b_num_l_reg;
    logic signed [NUM_W-1:0] b_num_r_reg;

    logic       tgt_valid_reg;
    wheel_tgt_t tgt_item_reg;

    logic load_a;
    logic load_b;
    logic load_c;

    logic signed [NUM_W-1:0] rw;
    logic signed [NUM_W-1:0] v1k;
    logic signed [NUM_W-1:0] abs_l;
    logic signed [NUM_W-1:0] abs_r;
    wheel_tgt_t              tgt_item_next;

    // A stage takes a new item when it is empty or its content moves on.
    assign load_c    = !tgt_valid_reg || tgt_ready;
    assign load_b    = !b_valid_reg || load_c;
    assign load_a    = !a_valid_reg || load_b;
    assign cmd.ready = load_a;

    assign tgt_valid = tgt_valid_reg;
    assign tgt_item  = tgt_item_reg;

    always_comb
    begin
        rw  = NUM_W'($signed({1'b0, cfg.radius})) * NUM_W'(a_w_reg);
        v1k = NUM_W'(a_v_reg) * KILO;
    end

    // Division truncates toward zero, so divide the magnitude and keep the sign aside.
    always_comb
    begin
        abs_l = b_num_l_reg[NUM_W-1] ? -b_num_l_reg : b_num_l_reg;
        abs_r = b_num_r_reg[NUM_W-1] ? -b_num_r_reg : b_num_r_reg;
        tgt_item_next.func   = b_func_reg;
        tgt_item_next.neg_l  = b_num_l_reg[NUM_W-1];
        tgt_item_next.quot_l = div1000(abs_l[MAG_W-1:0]);
        tgt_item_next.neg_r  = b_num_r_reg[NUM_W-1];
        tgt_item_next.quot_r = div1000(abs_r[MAG_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            tgt_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_a)
            begin
                a_valid_reg <= cmd.valid;
            end
            if (load_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (load_c)
            begin
                tgt_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_func_reg <= cmd.func;
            a_v_reg    <= cmd.lin_speed;
            a_w_reg    <= cmd.turn_rate;
        end
        if (load_b)
        begin
            b_func_reg  <= func_e'(a_func_reg);
            b_num_l_reg <= v1k - rw;
            b_num_r_reg <= v1k + rw;
        end
        if (load_c)
        begin
            tgt_item_reg <= tgt_item_next;
        end
    end

endmodule

FILE: design/ddsl_slew.sv
`timescale 1ns / 1ps

module ddsl_slew import ddsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       tgt_valid,
    output logic       tgt_ready,
    input  wheel_tgt_t tgt_item,
    output logic       sp_valid,
    input  logic       sp_ready,
    output sp_pair_t   sp_item
);

    localparam int unsigned STEP_PROD_W = ACCEL_W + PERIOD_W;
    localparam logic [STEP_PROD_W-1:0] STEP_PROD_RST = 26'd10000;
    localparam logic [STEP_W-1:0]      STEP_RST      = 17'd10;

    logic [STEP_PROD_W-1:0] step_prod_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [QUOT_W-1:0]      step_quot;

    logic signed [FIELD_W-1:0] tl_reg;
    logic signed [FIELD_W-1:0] tr_reg;
    logic signed [FIELD_W-1:0] sp_l_reg;
    logic signed [FIELD_W-1:0] sp_r_reg;
    logic                      sp_valid_reg;
    sp_pair_t                  sp_item_reg;

    logic signed [FIELD_W-1:0] tl_next;
    logic signed [FIELD_W-1:0] tr_next;
    logic signed [FIELD_W-1:0] sp_l_next;
    logic signed [FIELD_W-1:0] sp_r_next;
    logic                      take;

    function automatic logic signed [FIELD_W-1:0] wheel_target(input logic neg,
                                                               input logic [QUOT_W-1:0] quot);
        logic signed [QUOT_W:0] val;
        val = $signed({1'b0, quot});
        if (neg)
        begin
            val = -val;
        end
        return sat16(val);
    endfunction

    function automatic logic signed [FIELD_W-1:0] slew_to(input logic signed [FIELD_W-1:0] cur,
                                                          input logic signed [FIELD_W-1:0] tgt,
                                                          input logic [STEP_W-1:0] step);
        logic signed [STEP_W+1:0] diff;
        logic signed [STEP_W+1:0] stp;
        logic signed [STEP_W+1:0] sum;
        logic signed [FIELD_W-1:0] res;
        diff = (STEP_W+2)'(tgt) - (STEP_W+2)'(cur);
        stp  = $signed({2'b00, step});
        if (diff > stp)
        begin
            sum = (STEP_W+2)'(cur) + stp;
            res = sum[FIELD_W-1:0];
        end
        else if (-diff > stp)
        begin
            sum = (STEP_W+2)'(cur) - stp;
            res = sum[FIELD_W-1:0];
        end
        else
        begin
            res = tgt;
        end
        return res;
    endfunction

    // A command ends here, so it never waits on the result side.
    assign tgt_ready = (tgt_item.func == FUNC_CMD) || !sp_valid_reg || sp_ready;
    assign take      = tgt_valid && tgt_ready;
    assign sp_valid  = sp_valid_reg;
    assign sp_item   = sp_item_reg;

    assign step_quot = div1000({{(MAG_W-STEP_PROD_W){1'b0}}, step_prod_reg});

    always_comb
    begin
        tl_next   = wheel_target(tgt_item.neg_l, tgt_item.quot_l);
        tr_next   = wheel_target(tgt_item.neg_r, tgt_item.quot_r);
        sp_l_next = slew_to(sp_l_reg, tl_reg, step_reg);
        sp_r_next = slew_to(sp_r_reg, tr_reg, step_reg);
    end

    // The step limit follows the configuration through step_prod_reg and then step_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_prod_reg <= STEP_PROD_RST;
            step_reg      <= STEP_RST;
        end
        else
        begin
            step_prod_reg <= cfg.accel * STEP_PROD_W'(cfg.period);
            step_reg      <= step_quot[STEP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_reg       <= '0;
            tr_reg       <= '0;
            sp_l_reg     <= '0;
            sp_r_reg     <= '0;
            sp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                unique case (tgt_item.func)
                    FUNC_CMD:
                    begin
                        tl_reg <= tl_next;
                        tr_reg <= tr_next;
                    end
                    FUNC_TICK:
                    begin
                        sp_l_reg <= sp_l_next;
                        sp_r_reg <= sp_r_next;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (take && tgt_item.func == FUNC_TICK)
            begin
                sp_valid_reg <= 1'b1;
            end
            else if (sp_ready)
            begin
                sp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && tgt_item.func == FUNC_TICK)
        begin
            sp_item_reg.sp_l <= sp_l_next;
            sp_item_reg.sp_r <= sp_r_next;
        end
    end

endmodule

FILE: design/ddsl_rpm.sv
`timescale 1ns / 1ps

module ddsl_rpm import ddsl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      sp_valid,
    output logic      sp_ready,
    input  sp_pair_t  sp_item,
    ddsl_rpm_if.source rpm
);

    localparam int unsigned MAG_SP_W = FIELD_W + 1;
    localparam int unsigned PROD_W   = MAG_SP_W + SCALE_W;
    localparam int unsigned Q_W      = PROD_W - 16;

    logic              p_valid_reg;
    logic              p_neg_l_reg;
    logic              p_neg_r_reg;
    logic [PROD_W-1:0] p_prod_l_reg;
    logic [PROD_W-1:0] p_prod_r_reg;

    logic                      out_valid_reg;
    logic signed [FIELD_W-1:0] rpm_l_reg;
    logic signed [FIELD_W-1:0] rpm_r_reg;

    logic                       load_p;
    logic                       load_o;
    logic signed [MAG_SP_W-1:0] ext_l;
    logic signed [MAG_SP_W-1:0] ext_r;
    logic [MAG_SP_W-1:0]        mag_l;
    logic [MAG_SP_W-1:0]        mag_r;

    // Saturate the signed rpm; the negative side reaches one further.
    function automatic logic signed [FIELD_W-1:0] to_rpm(input logic neg,
                                                         input logic [Q_W-1:0] q);
        logic signed [FIELD_W-1:0] res;
        if (neg)
        begin
            if (q > Q_W'(32768))
            begin
                res = 16'sh8000;
            end
            else
            begin
                res = -$signed(q[FIELD_W-1:0]);
            end
        end
        else
        begin
            if (q > Q_W'(32767))
            begin
                res = 16'sh7FFF;
            end
            else
            begin
                res = $signed(q[FIELD_W-1:0]);
            end
        end
        return res;
    endfunction

    assign load_o   = !out_valid_reg || rpm.ready;
    assign load_p   = !p_valid_reg || load_o;
    assign sp_ready = load_p;

    assign rpm.valid     = out_valid_reg;
    assign rpm.left_rpm  = rpm_l_reg;
    assign rpm.right_rpm = rpm_r_reg;

    always_comb
    begin
        ext_l = MAG_SP_W'(sp_item.sp_l);
        ext_r = MAG_SP_W'(sp_item.sp_r);
        mag_l = ext_l[MAG_SP_W-1] ? MAG_SP_W'(-ext_l) : MAG_SP_W'(ext_l);
        mag_r = ext_r[MAG_SP_W-1] ? MAG_SP_W'(-ext_r) : MAG_SP_W'(ext_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_p)
            begin
                p_valid_reg <= sp_valid;
            end
            if (load_o)
            begin
                out_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_p)
        begin
            p_neg_l_reg  <= sp_item.sp_l[FIELD_W-1];
            p_neg_r_reg  <= sp_item.sp_r[FIELD_W-1];
            p_prod_l_reg <= PROD_W'(mag_l) * PROD_W'(cfg.scale);
            p_prod_r_reg <= PROD_W'(mag_r) * PROD_W'(cfg.scale);
        end
        if (load_o)
        begin
            rpm_l_reg <= to_rpm(p_neg_l_reg, p_prod_l_reg[PROD_W-1:16]);
            rpm_r_reg <= to_rpm(p_neg_r_reg, p_prod_r_reg[PROD_W-1:16]);
        end
    end

endmodule
